@@ sv/ncle_pkg.sv @@
package ncle_pkg;

  localparam int unsigned LfsrWidth  = 15;
  localparam int unsigned TimerWidth = 12;
  localparam int unsigned LenWidth   = 8;
  localparam int unsigned EnvWidth   = 4;

  typedef enum logic [2:0] {
    ACT_REG_WRITE    = 3'd0,
    ACT_ENABLE_WRITE = 3'd1,
    ACT_TIMER_TICK   = 3'd2,
    ACT_QUARTER      = 3'd3,
    ACT_HALF         = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    REG_ENVELOPE    = 2'd0,
    REG_UNUSED      = 2'd1,
    REG_MODE_PERIOD = 2'd2,
    REG_LENGTH_LOAD = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [3:0] level;
    logic       length_active;
  } result_t;

  function automatic logic [TimerWidth-1:0] period_lookup(input logic [3:0] sel);
    logic [TimerWidth-1:0] p;
    unique case (sel)
      4'd0:  p = 12'd4;
      4'd1:  p = 12'd8;
      4'd2:  p = 12'd16;
      4'd3:  p = 12'd32;
      4'd4:  p = 12'd64;
      4'd5:  p = 12'd96;
      4'd6:  p = 12'd128;
      4'd7:  p = 12'd160;
      4'd8:  p = 12'd202;
      4'd9:  p = 12'd254;
      4'd10: p = 12'd380;
      4'd11: p = 12'd508;
      4'd12: p = 12'd762;
      4'd13: p = 12'd1016;
      4'd14: p = 12'd2034;
      default: p = 12'd4068;
    endcase
    return p;
  endfunction

  function automatic logic [LenWidth-1:0] length_lookup(input logic [4:0] sel);
    logic [LenWidth-1:0] l;
    unique case (sel)
      5'd0:  l = 8'd10;
      5'd1:  l = 8'd254;
      5'd2:  l = 8'd20;
      5'd3:  l = 8'd2;
      5'd4:  l = 8'd40;
      5'd5:  l = 8'd4;
      5'd6:  l = 8'd80;
      5'd7:  l = 8'd6;
      5'd8:  l = 8'd160;
      5'd9:  l = 8'd8;
      5'd10: l = 8'd60;
      5'd11: l = 8'd10;
      5'd12: l = 8'd14;
      5'd13: l = 8'd12;
      5'd14: l = 8'd26;
      5'd15: l = 8'd14;
      5'd16: l = 8'd12;
      5'd17: l = 8'd16;
      5'd18: l = 8'd24;
      5'd19: l = 8'd18;
      5'd20: l = 8'd48;
      5'd21: l = 8'd20;
      5'd22: l = 8'd96;
      5'd23: l = 8'd22;
      5'd24: l = 8'd192;
      5'd25: l = 8'd24;
      5'd26: l = 8'd72;
      5'd27: l = 8'd26;
      5'd28: l = 8'd16;
      5'd29: l = 8'd28;
      5'd30: l = 8'd32;
      default: l = 8'd30;
    endcase
    return l;
  endfunction

endpackage

@@ sv/ncle_core.sv @@
module ncle_core import ncle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  action_e    action_i,
  input  logic [1:0] reg_index_i,
  input  logic [7:0] data_byte_i,
  input  logic       enable_bit_i,
  output result_t    result_o
);

  logic [LfsrWidth-1:0]  lfsr_q, lfsr_d;
  logic [TimerWidth-1:0] timer_count_q, timer_count_d;
  logic [TimerWidth-1:0] timer_reload_q, timer_reload_d;
  logic                  short_mode_q, short_mode_d;
  logic [LenWidth-1:0]   length_count_q, length_count_d;
  logic                  length_halt_off_q, length_halt_off_d;
  logic                  env_loop_q, env_loop_d;
  logic                  env_decay_on_q, env_decay_on_d;
  logic [EnvWidth-1:0]   env_period_q, env_period_d;
  logic                  env_restart_q, env_restart_d;
  logic [EnvWidth-1:0]   env_level_q, env_level_d;
  logic [EnvWidth-1:0]   env_divider_q, env_divider_d;
  logic                  chan_enabled_q, chan_enabled_d;
  logic                  feedback;

  assign feedback = lfsr_q[0] ^ (short_mode_q ? lfsr_q[6] : lfsr_q[1]);

  always_comb begin
    lfsr_d            = lfsr_q;
    timer_count_d     = timer_count_q;
    timer_reload_d    = timer_reload_q;
    short_mode_d      = short_mode_q;
    length_count_d    = length_count_q;
    length_halt_off_d = length_halt_off_q;
    env_loop_d        = env_loop_q;
    env_decay_on_d    = env_decay_on_q;
    env_period_d      = env_period_q;
    env_restart_d     = env_restart_q;
    env_level_d       = env_level_q;
    env_divider_d     = env_divider_q;
    chan_enabled_d    = chan_enabled_q;
    if (step_i) begin
      unique case (action_i)
        ACT_REG_WRITE: begin
          unique case (reg_index_e'(reg_index_i))
            REG_ENVELOPE: begin
              env_loop_d        = data_byte_i[5];
              length_halt_off_d = ~data_byte_i[5];
              env_decay_on_d    = ~data_byte_i[4];
              env_period_d      = data_byte_i[3:0];
              env_restart_d     = 1'b1;
            end
            REG_MODE_PERIOD: begin
              short_mode_d   = data_byte_i[7];
              timer_reload_d = period_lookup(data_byte_i[3:0]);
            end
            REG_LENGTH_LOAD: begin
              length_count_d = length_lookup(data_byte_i[7:3]);
              env_restart_d  = 1'b1;
            end
            default: ;
          endcase
        end
        ACT_ENABLE_WRITE: begin
          chan_enabled_d = enable_bit_i;
          if (!enable_bit_i) begin
            length_count_d = '0;
          end
        end
        ACT_TIMER_TICK: begin
          if (timer_count_q != '0) begin
            timer_count_d = timer_count_q - TimerWidth'(1);
          end else begin
            timer_count_d = timer_reload_q;
            lfsr_d        = {feedback, lfsr_q[LfsrWidth-1:1]};
          end
        end
        ACT_QUARTER: begin
          if (env_restart_q) begin
            env_level_d   = 4'hF;
            env_divider_d = env_period_q;
            env_restart_d = 1'b0;
          end else if (env_divider_q != '0) begin
            env_divider_d = env_divider_q - EnvWidth'(1);
          end else begin
            env_divider_d = env_period_q;
            if (env_level_q != '0) begin
              env_level_d = env_level_q - EnvWidth'(1);
            end else if (env_loop_q) begin
              env_level_d = 4'hF;
            end
          end
        end
        ACT_HALF: begin
          if (length_halt_off_q && length_count_q != '0) begin
            length_count_d = length_count_q - LenWidth'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.length_active = (length_count_d != '0);
    if (!chan_enabled_d || length_count_d == '0 || lfsr_d[0]) begin
      result_o.level = '0;
    end else begin
      result_o.level = env_decay_on_d ? env_level_d : env_period_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q            <= LfsrWidth'(1);
      timer_count_q     <= '0;
      timer_reload_q    <= '0;
      short_mode_q      <= 1'b0;
      length_count_q    <= '0;
      length_halt_off_q <= 1'b0;
      env_loop_q        <= 1'b0;
      env_decay_on_q    <= 1'b0;
      env_period_q      <= '0;
      env_restart_q     <= 1'b0;
      env_level_q       <= '0;
      env_divider_q     <= '0;
      chan_enabled_q    <= 1'b0;
    end else begin
      lfsr_q            <= lfsr_d;
      timer_count_q     <= timer_count_d;
      timer_reload_q    <= timer_reload_d;
      short_mode_q      <= short_mode_d;
      length_count_q    <= length_count_d;
      length_halt_off_q <= length_halt_off_d;
      env_loop_q        <= env_loop_d;
      env_decay_on_q    <= env_decay_on_d;
      env_period_q      <= env_period_d;
      env_restart_q     <= env_restart_d;
      env_level_q       <= env_level_d;
      env_divider_q     <= env_divider_d;
      chan_enabled_q    <= chan_enabled_d;
    end
  end

`ifndef SYNTH
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("lfsr reached zero");

  a_disable_clears_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && action_i == ACT_ENABLE_WRITE && !enable_bit_i) |=> length_count_q == '0)
    else $error("disable did not clear length counter");

  a_restart_loads_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && action_i == ACT_QUARTER && env_restart_q)
      |=> (env_level_q == 4'hF && !env_restart_q))
    else $error("envelope restart not applied");

  a_level_needs_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.level != '0) |-> result_o.length_active)
    else $error("nonzero level with idle length counter");
`endif

endmodule

@@ sv/noise_channel_lfsr_envelope.sv @@
// Noise channel: 15-bit LFSR source, period timer, decay envelope, length counter.
//
// Input stream (s_axis): one event per transfer. tuser carries the action
// (register write, enable write, timer tick, quarter frame, half frame);
// tdata carries register offset, data byte and enable bit.
// Output stream (m_axis): one result per input event, in order, giving the
// gated 4-bit level and the length-active flag after that event is applied.
//
// Timing: an event is captured in the input register; when the result queue
// has room it is applied to the channel state, and its result is written into
// the queue on the same edge, from which m_axis presents it.
// Throughput: one event per cycle while the result queue has room, with a
// two-entry result queue that lets the next event enter while a result waits.
//
// Reset clears all channel state (LFSR to 1, everything else to 0) and empties
// the pipeline. When the receiver stalls, results collect in the queue; once
// it holds two, the input register holds its event and s_axis_tready drops.
module noise_channel_lfsr_envelope import ncle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] reg_index, [9:2] data_byte, [10] enable_bit, [15:11] zero
  input  logic [15:0] s_axis_tdata,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] level, [4] length_active, [7:5] zero
  output logic [7:0]  m_axis_tdata
);

  logic        in_valid_q;
  logic [2:0]  action_q;
  logic [1:0]  reg_index_q;
  logic [7:0]  data_byte_q;
  logic        enable_bit_q;
  logic        step;
  logic        push;
  logic        pop;
  logic [1:0]  count_q;
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  result_t     fifo_q [2];
  result_t     result;

  assign step          = in_valid_q && (count_q != 2'd2);
  assign s_axis_tready = !in_valid_q || step;
  assign push          = step;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      action_q     <= s_axis_tuser;
      reg_index_q  <= s_axis_tdata[1:0];
      data_byte_q  <= s_axis_tdata[9:2];
      enable_bit_q <= s_axis_tdata[10];
    end
  end

  ncle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .action_i    (action_e'(action_q)),
    .reg_index_i (reg_index_q),
    .data_byte_i (data_byte_q),
    .enable_bit_i(enable_bit_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= result;
    end
  end

  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {3'b000, fifo_q[rd_ptr_q].length_active, fifo_q[rd_ptr_q].level};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("result queue overflow");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !push) else $error("push into full queue");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && count_q == 2'd2) |=> in_valid_q)
    else $error("input event dropped during stall");
`endif

endmodule

@@ sim/noise_channel_lfsr_envelope_tb.sv @@
`timescale 1ns / 100ps

module noise_channel_lfsr_envelope_tb;
  import ncle_pkg::*;

  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 1200;
  localparam logic [2:0] ActReservedFirst = 3'd5;
  localparam logic [2:0] ActReservedLast  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  logic [TimerWidth-1:0] period_tab [16] = '{
    12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
    12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
  };
  logic [LenWidth-1:0] length_tab [32] = '{
    8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
    8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  logic [LfsrWidth-1:0]  noise_sr;
  logic [TimerWidth-1:0] tmr_count;
  logic [TimerWidth-1:0] tmr_reload;
  logic                  short_taps;
  logic [LenWidth-1:0]   length_left;
  logic                  length_run;
  logic                  env_loop_q;
  logic                  env_decay;
  logic                  env_restart_q;
  logic                  chan_en;
  logic [EnvWidth-1:0]   env_per;
  logic [EnvWidth-1:0]   env_lvl;
  logic [EnvWidth-1:0]   env_div;

  result_t     channel_out_q [$];
  int unsigned err_count   = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_audible   = 0;
  int unsigned idle_cycles = 0;
  int unsigned act_seen [8];
  logic        src_calm      = 1'b0;
  logic        sink_calm     = 1'b0;
  logic        sink_hold_req = 1'b0;

  noise_channel_lfsr_envelope i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 4) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic void reset_channel_model();
    noise_sr      = 'd1;
    tmr_count     = '0;
    tmr_reload    = '0;
    short_taps    = 1'b0;
    length_left   = '0;
    length_run    = 1'b0;
    env_loop_q    = 1'b0;
    env_decay     = 1'b0;
    env_restart_q = 1'b0;
    chan_en       = 1'b0;
    env_per       = '0;
    env_lvl       = '0;
    env_div       = '0;
    for (int i = 0; i < 8; i++) act_seen[i] = 0;
  endfunction

  function automatic result_t apply_channel_event(input logic [2:0] act, input logic [1:0] idx,
                                                  input logic [7:0] d, input logic en);
    result_t r;
    logic    fb;
    act_seen[act]++;
    case (act)
      ACT_REG_WRITE: begin
        case (idx)
          REG_ENVELOPE: begin
            env_loop_q    = d[5];
            length_run    = ~d[5];
            env_decay     = ~d[4];
            env_per       = d[3:0];
            env_restart_q = 1'b1;
          end
          REG_MODE_PERIOD: begin
            short_taps = d[7];
            tmr_reload = period_tab[d[3:0]];
          end
          REG_LENGTH_LOAD: begin
            length_left   = length_tab[d[7:3]];
            env_restart_q = 1'b1;
          end
          default: ;
        endcase
      end
      ACT_ENABLE_WRITE: begin
        chan_en = en;
        if (!en) length_left = '0;
      end
      ACT_TIMER_TICK: begin
        if (tmr_count != '0) begin
          tmr_count = tmr_count - TimerWidth'(1);
        end else begin
          fb        = noise_sr[0] ^ (short_taps ? noise_sr[6] : noise_sr[1]);
          tmr_count = tmr_reload;
          noise_sr  = {fb, noise_sr[LfsrWidth-1:1]};
        end
      end
      ACT_QUARTER: begin
        if (env_restart_q) begin
          env_lvl       = 4'd15;
          env_div       = env_per;
          env_restart_q = 1'b0;
        end else if (env_div != '0) begin
          env_div = env_div - EnvWidth'(1);
        end else begin
          env_div = env_per;
          if (env_lvl != '0) env_lvl = env_lvl - EnvWidth'(1);
          else if (env_loop_q) env_lvl = 4'd15;
        end
      end
      ACT_HALF: begin
        if (length_run && length_left != '0) length_left = length_left - LenWidth'(1);
      end
      default: ;
    endcase
    if (!chan_en || length_left == '0 || noise_sr[0]) r.level = '0;
    else r.level = env_decay ? env_lvl : env_per;
    r.length_active = (length_left != '0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d, t=%0t)",
             what, got, want, n_checked, $realtime);
    err_count++;
  endtask

  task automatic send_event(input logic [2:0] act, input logic [1:0] idx,
                            input logic [7:0] d, input logic en);
    int unsigned gap;
    gap = (!src_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, en, d, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    channel_out_q.push_back(apply_channel_event(act, idx, d, en));
    n_sent++;
  endtask

  task automatic send_action(input logic [2:0] act);
    send_event(act, 2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic test_reserved_actions();
    for (int a = ActReservedFirst; a <= ActReservedLast; a++)
      send_action(a[2:0]);
    send_action(ACT_TIMER_TICK);
  endtask

  task automatic test_register_writes();
    send_event(ACT_ENABLE_WRITE, REG_ENVELOPE, 8'h00, 1'b1);
    send_event(ACT_REG_WRITE, REG_ENVELOPE, 8'h3F, 1'b0);
    send_event(ACT_REG_WRITE, REG_UNUSED, 8'hFF, 1'b1);
    send_event(ACT_REG_WRITE, REG_MODE_PERIOD, 8'h8F, 1'b0);
    send_event(ACT_REG_WRITE, REG_LENGTH_LOAD, 8'hF8, 1'b1);
    send_event(ACT_REG_WRITE, REG_MODE_PERIOD, 8'h00, 1'b0);
    send_event(ACT_REG_WRITE, REG_LENGTH_LOAD, 8'h08, 1'b1);
  endtask

  task automatic test_envelope();
    send_event(ACT_REG_WRITE, REG_ENVELOPE, 8'h00, 1'b0);
    repeat (3) send_action(ACT_QUARTER);
    send_event(ACT_REG_WRITE, REG_ENVELOPE, 8'h20, 1'b1);
    send_action(ACT_QUARTER);
  endtask

  task automatic test_length_counter();
    send_event(ACT_REG_WRITE, REG_ENVELOPE, 8'h10, 1'b0);
    send_event(ACT_REG_WRITE, REG_LENGTH_LOAD, 8'h18, 1'b0);
    repeat (3) send_action(ACT_HALF);
    send_event(ACT_ENABLE_WRITE, REG_UNUSED, 8'hAA, 1'b0);
    send_action(ACT_HALF);
  endtask

  task automatic test_lfsr_short_mode();
    send_event(ACT_REG_WRITE, REG_MODE_PERIOD, 8'h80, 1'b1);
    repeat (3) send_action(ACT_TIMER_TICK);
  endtask

  task automatic test_input_backpressure();
    src_calm      = 1'b1;
    sink_hold_req = 1'b1;
    repeat (24)
      send_action($urandom_range(0, 1) ? ACT_TIMER_TICK : ACT_QUARTER);
    src_calm = 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    logic [7:0]  d;
    sent = 0;
    while (sent < n_items) begin
      src_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_event(ACT_ENABLE_WRITE, 2'($urandom), 8'($urandom), 1'b1);
        d = 8'($urandom);
        if ($urandom_range(0, 1)) d[3:0] = 4'($urandom_range(0, 2));
        send_event(ACT_REG_WRITE, REG_ENVELOPE, d, 1'($urandom));
        d = 8'($urandom);
        if ($urandom_range(0, 3) != 0) d[3:0] = 4'($urandom_range(0, 2));
        send_event(ACT_REG_WRITE, REG_MODE_PERIOD, d, 1'($urandom));
        send_event(ACT_REG_WRITE, REG_LENGTH_LOAD, 8'($urandom), 1'($urandom));
        burst = $urandom_range(20, 60);
        for (int i = 0; i < burst; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 55)
            send_action(ACT_TIMER_TICK);
          else if (pick < 80)
            send_action(ACT_QUARTER);
          else if (pick < 92)
            send_action(ACT_HALF);
          else if (pick < 96)
            send_action(ACT_REG_WRITE);
          else if (pick < 98)
            send_event(ACT_ENABLE_WRITE, 2'($urandom), 8'($urandom),
                       $urandom_range(0, 7) != 0);
          else
            send_action(3'($urandom_range(ActReservedFirst, ActReservedLast)));
        end
        sent += 4 + burst;
      end else begin
        burst = $urandom_range(5, 20);
        repeat (burst) send_action(3'($urandom_range(0, 7)));
        sent += burst;
      end
    end
  endtask

  initial begin
    int unsigned sink_wait;
    sink_wait     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 149) == 0) sink_calm = ~sink_calm;
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_wait     = HoldCycles;
      end else if (sink_wait == 0 && !sink_calm && $urandom_range(0, 3) == 0) begin
        sink_wait = pick_gap();
      end
      if (sink_wait > 0) begin
        m_axis_tready <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (channel_out_q.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, 8'h00);
      end else begin
        want = channel_out_q.pop_front();
        n_checked++;
        if (m_axis_tdata[3:0] !== want.level)
          report_mismatch("level", 8'(m_axis_tdata[3:0]), 8'(want.level));
        if (m_axis_tdata[4] !== want.length_active)
          report_mismatch("length_active", 8'(m_axis_tdata[4]), 8'(want.length_active));
        if (want.level != '0) n_audible++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer in %0d cycles, %0d results pending",
               idle_cycles, channel_out_q.size());
      $display("noise_channel_lfsr_envelope_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    reset_channel_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reserved_actions();
    test_register_writes();
    test_envelope();
    test_length_counter();
    test_lfsr_short_mode();
    test_input_backpressure();
    test_random_traffic(RandomItems);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (channel_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d events: %0d reg, %0d en, %0d tick, %0d qtr, %0d half, %0d rsvd",
             n_sent, act_seen[ACT_REG_WRITE], act_seen[ACT_ENABLE_WRITE],
             act_seen[ACT_TIMER_TICK], act_seen[ACT_QUARTER], act_seen[ACT_HALF],
             act_seen[5] + act_seen[6] + act_seen[7]);
    $display("checked %0d results, %0d with the channel audible, %0d mismatches",
             n_checked, n_audible, err_count);
    if (err_count == 0) $display("noise_channel_lfsr_envelope_tb: clean");
    else $display("noise_channel_lfsr_envelope_tb: errors");
    $finish;
  end

endmodule
